// ===== design/dwsg_pkg.sv =====
`default_nettype none
package dwsg_pkg;
	localparam int MaxPeriod = 16384;
	localparam int NBits = 15;
	localparam int IdxBits = 14;
	localparam int QuotBits = 24;
	localparam int CordicSteps = 18;
	localparam int CwBits = 21;

	localparam logic [1:0] MODE_SINE_A = 2'd0;
	localparam logic [1:0] MODE_SINE_B = 2'd1;
	localparam logic [1:0] MODE_TRI = 2'd2;
	localparam logic [1:0] MODE_SQUARE = 2'd3;

	localparam logic REG_PERIOD = 1'b0;
	localparam logic REG_MODE = 1'b1;

	typedef struct packed {
		logic [1:0] mode;
		logic       oor;
		logic [1:0] quad;
		logic [11:0] alt_code;
	} side_t;

	function automatic logic signed [CwBits-1:0] atan_q(input int k);
		case (k)
			0: atan_q = 21'sd102944;
			1: atan_q = 21'sd60771;
			2: atan_q = 21'sd32110;
			3: atan_q = 21'sd16299;
			4: atan_q = 21'sd8181;
			5: atan_q = 21'sd4095;
			6: atan_q = 21'sd2048;
			7: atan_q = 21'sd1024;
			8: atan_q = 21'sd512;
			9: atan_q = 21'sd256;
			10: atan_q = 21'sd128;
			11: atan_q = 21'sd64;
			12: atan_q = 21'sd32;
			13: atan_q = 21'sd16;
			14: atan_q = 21'sd8;
			15: atan_q = 21'sd4;
			16: atan_q = 21'sd2;
			17: atan_q = 21'sd1;
			default: atan_q = 21'sd0;
		endcase
	endfunction
endpackage
`default_nettype wire

// ===== design/dwsg_div.sv =====
`default_nettype none
// Pipelined restoring divider: num / den, one quotient bit per stage.
module dwsg_div import dwsg_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic [QuotBits+IdxBits-1:0] num,
	input  wire logic [NBits-1:0]      den,
	input  wire side_t                 in_side,
	output logic                       out_valid,
	output logic [QuotBits-1:0]        quot,
	output side_t                      out_side
);
	localparam int NumW = QuotBits + IdxBits;
	localparam int St = QuotBits;
	// numerator < den*2^24 so only the low 24 quotient bits are ever set;
	// the top numerator bits preload the remainder
	logic [NBits:0]      rem_s  [St+1];
	logic [NumW-1:0]     num_s  [St+1];
	logic [NBits-1:0]    den_s  [St+1];
	logic [QuotBits-1:0] q_s    [St+1];
	side_t               side_s [St+1];
	logic                v_s    [St+1];

	always_comb begin
		rem_s[0] = {2'b00, num[NumW-1:QuotBits]};
		num_s[0] = num;
		den_s[0] = den;
		q_s[0] = '0;
		side_s[0] = in_side;
		v_s[0] = in_valid;
	end

	for (genvar g = 0; g < St; g++) begin : g_st
		logic [NBits+1:0] trial;
		logic [NBits+1:0] diff;
		always_comb begin
			trial = {rem_s[g], num_s[g][QuotBits-1-g]};
			diff = trial - {2'b00, den_s[g]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else begin
				v_s[g+1] <= v_s[g];
			end
		end
		always_ff @(posedge clk) begin
			num_s[g+1] <= num_s[g];
			den_s[g+1] <= den_s[g];
			side_s[g+1] <= side_s[g];
			if (!diff[NBits+1]) begin
				rem_s[g+1] <= diff[NBits:0];
				q_s[g+1] <= {q_s[g][QuotBits-2:0], 1'b1};
			end else begin
				rem_s[g+1] <= trial[NBits:0];
				q_s[g+1] <= {q_s[g][QuotBits-2:0], 1'b0};
			end
		end
	end

	assign out_valid = v_s[St];
	assign quot = q_s[St];
	assign out_side = side_s[St];
endmodule
`default_nettype wire

// ===== design/dwsg_cordic.sv =====
`default_nettype none
// Rotation-mode CORDIC, one micro-rotation per stage.
module dwsg_cordic import dwsg_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic signed [CwBits-1:0] angle,
	input  wire side_t                    in_side,
	output logic                          out_valid,
	output logic signed [CwBits-1:0]      cos_q,
	output logic signed [CwBits-1:0]      sin_q,
	output side_t                         out_side
);
	logic signed [CwBits-1:0] x_s [CordicSteps+1];
	logic signed [CwBits-1:0] y_s [CordicSteps+1];
	logic signed [CwBits-1:0] z_s [CordicSteps+1];
	side_t                    sd_s [CordicSteps+1];
	logic                     v_s [CordicSteps+1];

	always_comb begin
		x_s[0] = 21'sd79594;
		y_s[0] = '0;
		z_s[0] = angle;
		sd_s[0] = in_side;
		v_s[0] = in_valid;
	end

	for (genvar k = 0; k < CordicSteps; k++) begin : g_rot
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_s[k];
			end
		end
		always_ff @(posedge clk) begin
			sd_s[k+1] <= sd_s[k];
			if (!z_s[k][CwBits-1]) begin
				x_s[k+1] <= x_s[k] - (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] + (x_s[k] >>> k);
				z_s[k+1] <= z_s[k] - atan_q(k);
			end else begin
				x_s[k+1] <= x_s[k] + (y_s[k] >>> k);
				y_s[k+1] <= y_s[k] - (x_s[k] >>> k);
				z_s[k+1] <= z_s[k] + atan_q(k);
			end
		end
	end

	assign out_valid = v_s[CordicSteps];
	assign cos_q = x_s[CordicSteps];
	assign sin_q = y_s[CordicSteps];
	assign out_side = sd_s[CordicSteps];
endmodule
`default_nettype wire

// ===== design/dac_waveform_sample_generator.sv =====
`default_nettype none
// DAC waveform sample generator.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index 0 = period
// length N (15 bits, clamped to 16384), 1 = waveform mode. cfg_ready is
// always high; write only while no request is in flight.
// Requests: pulse start with sample_index while busy is low; busy is
// never asserted, so one request may enter every cycle.
// Results: dac_code and index_out_of_range appear for one cycle with
// result_valid at the end of the pipeline (the input stage is loaded at
// the accepting edge, then 24 divider stages, one angle multiply stage,
// 18 CORDIC stages, three output stages). Triangle and
// square codes travel alongside the same pipeline so order is kept.
// Throughput is one sample per clock; the receiver cannot stall.
// Reset clears the valid pipeline and sets N = 10000, mode = sine A.
module dac_waveform_sample_generator import dwsg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [13:0] sample_index,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [14:0] cfg_data,
	output logic             result_valid,
	output logic [11:0]      dac_code,
	output logic             index_out_of_range
);
	logic [NBits-1:0] period_q;
	logic [1:0]       mode_q;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= 15'd10000;
			mode_q <= MODE_SINE_A;
		end else if (cfg_valid) begin
			if (cfg_index == REG_PERIOD) period_q <= cfg_data;
			else mode_q <= cfg_data[1:0];
		end
	end

	// stage 1: range check, triangle numerator, square code
	logic [NBits-1:0] n_c;
	logic [NBits-1:0] half_c;
	logic [IdxBits:0] m_c;
	logic             oor_c;
	always_comb begin
		n_c = (period_q > NBits'(MaxPeriod)) ? NBits'(MaxPeriod) : period_q;
		half_c = n_c >> 1;
		oor_c = ({1'b0, sample_index} >= n_c);
		if ({1'b0, sample_index} <= half_c) m_c = {1'b0, sample_index};
		else m_c = (IdxBits+1)'({half_c, 1'b0} - {1'b0, sample_index});
	end

	logic                          v_s1;
	logic [QuotBits+IdxBits-1:0]   num_s1;
	logic [NBits-1:0]              n_s1;
	side_t                         side_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start;
	end
	always_ff @(posedge clk) begin
		n_s1 <= (n_c == '0) ? NBits'(1) : n_c;
		side_s1.mode <= mode_q;
		side_s1.oor <= oor_c;
		side_s1.quad <= '0;
		side_s1.alt_code <= ({1'b0, sample_index} < half_c) ? 12'd100 : 12'd4095;
		if (mode_q == MODE_TRI)
			num_s1 <= {12'd0, 26'(m_c) * 26'd7990};
		else
			num_s1 <= {sample_index, {QuotBits{1'b0}}};
	end

	logic                 dv;
	logic [QuotBits-1:0]  quot;
	side_t                dside;
	dwsg_div u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s1), .num(num_s1), .den(n_s1),
		.in_side(side_s1), .out_valid(dv), .quot(quot), .out_side(dside)
	);

	// angle: r * pi/2 in Q17; triangle code resolved here
	logic                     v_s2;
	logic signed [CwBits-1:0] ang_s2;
	side_t                    side_s2;
	logic [39:0]              prod_c;
	always_comb prod_c = {18'd0, quot[21:0]} * 40'd205887;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= dv;
	end
	always_ff @(posedge clk) begin
		ang_s2 <= CwBits'(prod_c[39:22]);
		side_s2.mode <= dside.mode;
		side_s2.oor <= dside.oor;
		side_s2.quad <= quot[23:22];
		side_s2.alt_code <= (dside.mode == MODE_TRI) ? 12'(quot + 24'd100)
			: dside.alt_code;
	end

	logic                     cv;
	logic signed [CwBits-1:0] cx, cy;
	side_t                    cside;
	dwsg_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s2), .angle(ang_s2),
		.in_side(side_s2), .out_valid(cv), .cos_q(cx), .sin_q(cy), .out_side(cside)
	);

	// quadrant fold and clamp
	logic                     v_s3;
	logic signed [CwBits-1:0] s_c, sn_s3;
	side_t                    side_s3;
	always_comb begin
		case (cside.quad)
			2'd0: s_c = cy;
			2'd1: s_c = cx;
			2'd2: s_c = -cy;
			default: s_c = -cx;
		endcase
		if (s_c > 21'sd131072) s_c = 21'sd131072;
		if (s_c < -21'sd131072) s_c = -21'sd131072;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= cv;
	end
	always_ff @(posedge clk) begin
		sn_s3 <= s_c;
		side_s3 <= cside;
	end

	// scale multiply
	logic               v_s4;
	logic signed [35:0] pa_s4;
	logic [35:0]        pb_s4;
	side_t              side_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end
	always_ff @(posedge clk) begin
		pa_s4 <= 36'(sn_s3) * 36'sd1998 + 36'sd268435456;
		pb_s4 <= 36'(unsigned'(19'(sn_s3 + 21'sd131072))) * 36'd24975;
		side_s4 <= side_s3;
	end

	// divide by 33*2^17: shift, then reciprocal multiply (2^21/33 rounded up),
	// exact for every shifted value up to 49950
	logic [15:0] t_c;
	logic [31:0] rq_c;
	logic [10:0] qb_c;
	logic [11:0] code_c;
	always_comb begin
		t_c = 16'(pb_s4 >> 17);
		rq_c = {16'd0, t_c} * 32'd63551;
		qb_c = rq_c[31:21];
		case (side_s4.mode)
			MODE_SINE_A: code_c = 12'(pa_s4 >>> 17);
			MODE_SINE_B: code_c = 12'(qb_c) + 12'd50;
			default: code_c = side_s4.alt_code;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) result_valid <= 1'b0;
		else result_valid <= v_s4;
	end
	always_ff @(posedge clk) begin
		index_out_of_range <= side_s4.oor;
		dac_code <= side_s4.oor ? 12'd0 : code_c;
	end

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && index_out_of_range |-> dac_code == 12'd0)
		else $error("out of range code not zero");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |=> result_valid) else $error("valid lost");
	a_sq: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !side_s4.oor && side_s4.mode == MODE_SQUARE
		|-> side_s4.alt_code == 12'd100 || side_s4.alt_code == 12'd4095)
		else $error("square code");
endmodule
`default_nettype wire

// ===== bench/dac_waveform_sample_generator_test.sv =====
`timescale 1ns / 1ps
module dac_waveform_sample_generator_test;
	import dwsg_pkg::*;

	typedef struct packed {
		logic [11:0] code;
		logic        oor;
	} sample_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [13:0] sample_index;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [14:0] cfg_data;
	logic        result_valid;
	logic [11:0] dac_code;
	logic        index_out_of_range;

	// shadow copy of the block's registers
	logic [14:0] period_reg;
	logic [1:0]  mode_reg;

	sample_t expected_samples[$];
	int errors;
	int samples_sent;
	int samples_checked;
	int writes_done;
	int mode_hits[4];
	int oor_hits;

	dac_waveform_sample_generator u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.sample_index(sample_index),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.result_valid(result_valid),
		.dac_code(dac_code),
		.index_out_of_range(index_out_of_range)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Q17 sine of one turn times i/n via an 18-step rotation
	function automatic longint sine_q17(longint i, longint n);
		longint arctan[18];
		longint p, r, z, x, y, s, dx, dy;
		logic [1:0] quad;
		arctan = '{102944, 60771, 32110, 16299, 8181, 4095, 2048, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2, 1};
		p = (i << 24) / n;
		quad = p[23:22];
		r = p & 64'h3F_FFFF;
		z = (r * 205887) >>> 22;
		x = 79594;
		y = 0;
		for (int k = 0; k < 18; k++) begin
			dx = y >>> k;
			dy = x >>> k;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - arctan[k];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + arctan[k];
			end
		end
		case (quad)
			2'd0: s = y;
			2'd1: s = x;
			2'd2: s = -y;
			default: s = -x;
		endcase
		if (s > 131072) s = 131072;
		if (s < -131072) s = -131072;
		return s;
	endfunction

	function automatic sample_t dac_code_for(logic [13:0] idx);
		sample_t res;
		longint n, i, half, m, v;
		n = period_reg;
		i = idx;
		if (n > MaxPeriod) n = MaxPeriod;
		res = '0;
		if (i >= n) begin
			res.oor = 1'b1;
			return res;
		end
		half = n / 2;
		case (mode_reg)
			MODE_SINE_A: begin
				v = (longint'(2048) << 17) + sine_q17(i, n) * 1998;
				v = v >>> 17;
			end
			MODE_SINE_B: v = ((sine_q17(i, n) + 131072) * 24975) / (33 * 131072) + 50;
			MODE_TRI: begin
				m = (i <= half) ? i : (2 * half - i);
				v = (7990 * m) / n + 100;
			end
			default: v = (i < half) ? 100 : 4095;
		endcase
		res.code = v[11:0];
		return res;
	endfunction

	task automatic send_sample(logic [13:0] idx, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		sample_index <= idx;
		forever begin
			@(negedge clk);
			if (!busy) break;
			@(posedge clk);
		end
		@(posedge clk);
		expected_samples.push_back(dac_code_for(idx));
		samples_sent++;
		if (idx >= period_reg || period_reg == 0) oor_hits++;
		else mode_hits[mode_reg]++;
	endtask

	task automatic go_idle();
		start <= 1'b0;
		while (expected_samples.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic which, logic [14:0] value);
		go_idle();
		cfg_valid <= 1'b1;
		cfg_index <= which;
		cfg_data <= value;
		forever begin
			@(negedge clk);
			if (cfg_ready) break;
			@(posedge clk);
		end
		@(posedge clk);
		cfg_valid <= 1'b0;
		if (which == REG_PERIOD) period_reg = value;
		else mode_reg = value[1:0];
		writes_done++;
	endtask

	task automatic test_reset_defaults();
		send_sample(14'd0, 0);
		send_sample(14'd2500, 0);
		send_sample(14'd9999, 1);
		send_sample(14'd10000, 0);
		send_sample(14'd16383, 0);
	endtask

	// every mode at the widest period, around the half-way point and the edge
	task automatic test_modes_full_period();
		write_reg(REG_PERIOD, 15'd16384);
		for (int md = 0; md < 4; md++) begin
			write_reg(REG_MODE, 15'(md));
			send_sample(14'd0, 0);
			send_sample(14'd8191, 0);
			send_sample(14'd8192, 0);
			send_sample(14'd12288, 0);
			send_sample(14'd16383, 0);
		end
	endtask

	task automatic test_odd_periods();
		// period saturates above the maximum
		write_reg(REG_PERIOD, 15'h7FFF);
		send_sample(14'h2AAA, 0);
		send_sample(14'h3FFF, 0);
		write_reg(REG_PERIOD, 15'd1);
		for (int md = 0; md < 4; md++) begin
			write_reg(REG_MODE, 15'(md));
			send_sample(14'd0, 0);
			send_sample(14'd1, 0);
		end
		write_reg(REG_PERIOD, 15'd0);
		send_sample(14'd0, 0);
		write_reg(REG_PERIOD, 15'd3);
		write_reg(REG_MODE, {13'd0, MODE_TRI});
		send_sample(14'd1, 0);
		send_sample(14'd2, 0);
	endtask

	task automatic test_random(int count);
		int left;
		int burst;
		logic [14:0] n;
		logic [13:0] idx;
		left = count;
		while (left > 0) begin
			case ($urandom_range(0, 5))
				0: n = 15'd16384;
				1: n = 15'($urandom_range(1, 4));
				2: n = 15'($urandom);
				default: n = 15'($urandom_range(2, 16384));
			endcase
			write_reg(REG_PERIOD, n);
			write_reg(REG_MODE, 15'($urandom_range(0, 3)));
			burst = $urandom_range(20, 60);
			for (int b = 0; b < burst && left > 0; b++) begin
				if ($urandom_range(0, 9) == 0 || n == 0) idx = 14'($urandom);
				else idx = 14'($urandom_range(0, (n > 16384 ? 16384 : n) - 1));
				// run some bursts back to back
				send_sample(idx, (burst > 50) ? 0 : $urandom_range(0, 9));
				left--;
			end
		end
	endtask

	always @(negedge clk) begin
		sample_t want;
		if (arst_n && result_valid) begin
			if (expected_samples.size() == 0) begin
				$display("%0t: unexpected result code=%0d oor=%0b", $time, dac_code,
					index_out_of_range);
				errors++;
			end else begin
				want = expected_samples.pop_front();
				samples_checked++;
				if (dac_code !== want.code) begin
					$display("%0t: dac_code expected %0d actual %0d", $time, want.code,
						dac_code);
					errors++;
				end
				if (index_out_of_range !== want.oor) begin
					$display("%0t: index_out_of_range expected %0b actual %0b", $time,
						want.oor, index_out_of_range);
					errors++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("dac_waveform_sample_generator regression: fail");
		$finish;
	end

	initial begin
		errors = 0;
		samples_sent = 0;
		samples_checked = 0;
		writes_done = 0;
		oor_hits = 0;
		mode_hits = '{0, 0, 0, 0};
		period_reg = 15'd10000;
		mode_reg = MODE_SINE_A;
		arst_n = 1'b0;
		start = 1'b0;
		sample_index = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_PERIOD;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_modes_full_period();
		test_odd_periods();
		test_random(850);
		go_idle();
		repeat (60) @(posedge clk);
		if (expected_samples.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_samples.size());
			errors++;
		end
		$display("%0d samples checked, %0d register writes", samples_checked, writes_done);
		$display("per mode sine A/sine B/triangle/square: %0d/%0d/%0d/%0d, out of range: %0d",
			mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], oor_hits);
		if (errors == 0) begin
			$display("dac_waveform_sample_generator regression: pass");
		end else begin
			$display("dac_waveform_sample_generator regression: fail");
		end
		$finish;
	end
endmodule

// ===== sim.f =====
design/dwsg_pkg.sv
design/dwsg_div.sv
design/dwsg_cordic.sv
design/dac_waveform_sample_generator.sv
bench/dac_waveform_sample_generator_test.sv
